// ===== rtl/csdm_pkg.sv =====
// Package with widths, constants and the CORDIC angle table for the disk map.
package csdm_pkg;
   localparam int SampleBits = 16;
   localparam int DivSteps = 14;
   localparam int CordicSteps = 16;
   localparam int CordicGain = 39797;
   localparam int PhEighth = 8192;
   // Full-width accumulator for the CORDIC x/y values.
   localparam int AccBits = 36;

   typedef logic signed [AccBits-1:0] acc_type;

   // Arctangent table in phase units, where 65536 is one full turn.
   function automatic logic [13:0] atan_entry(input logic [3:0] idx);
      logic [13:0] v;
      begin
         case (idx)
            4'd0: v = 14'd8192;
            4'd1: v = 14'd4836;
            4'd2: v = 14'd2555;
            4'd3: v = 14'd1297;
            4'd4: v = 14'd651;
            4'd5: v = 14'd326;
            4'd6: v = 14'd163;
            4'd7: v = 14'd81;
            4'd8: v = 14'd41;
            4'd9: v = 14'd20;
            4'd10: v = 14'd10;
            4'd11: v = 14'd5;
            4'd12: v = 14'd3;
            4'd13: v = 14'd1;
            4'd14: v = 14'd1;
            default: v = 14'd0;
         endcase
         return v;
      end
   endfunction
endpackage

// ===== rtl/concentric_square_to_disk_map_unit.sv =====
// Top level of the concentric square-to-disk map.
// Usage:
//   The req_ channel carries one sample point per item; tdata holds sample_x
//   in bits 15:0 and sample_y in bits 31:16, unsigned fractions in [0,1).
//   The rsp_ channel returns one disk point per item; tdata holds disk_x in
//   bits 15:0 and disk_y in bits 31:16, signed Q1.15.
//   The block is a fully pipelined datapath: one item may enter every cycle
//   and the throughput is one item per clock while the receiver does not
//   stall. The pipeline has 33 register stages: one setup stage, fourteen
//   restoring-division stages of one quotient bit each for the minor/major
//   ratio, one phase stage, sixteen CORDIC rotation stages and one rounding
//   and saturation stage. The division chain and the CORDIC chain set the
//   depth.
//   Synchronous reset empties the pipeline; no result is pending after it.
//   When the receiver stalls, the whole pipeline holds and req_tready falls
//   only while the last stage holds an untaken result, so nothing is lost
//   or repeated.
module concentric_square_to_disk_map_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // sample_x [15:0], sample_y [31:16]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata    // disk_x [15:0], disk_y [31:16]
);
   logic [15:0] disk_x, disk_y;

   // Datapath pipeline.
   csdm_pipe u_pipe (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_a      (req_tdata[15:0]),
      .in_b      (req_tdata[31:16]),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_x     (disk_x),
      .out_y     (disk_y)
   );

   assign rsp_tdata = {disk_y, disk_x};
endmodule

// ===== rtl/csdm_pipe.sv =====
// Stall-able pipeline: sector select, ratio division, CORDIC rotation, quadrant fix.
module csdm_pipe (
   input  logic        clock,
   input  logic        reset,
   input  logic        in_valid,
   output logic        in_ready,
   input  logic [15:0] in_a,
   input  logic [15:0] in_b,
   output logic        out_valid,
   input  logic        out_ready,
   output logic [15:0] out_x,
   output logic [15:0] out_y
);
   // Stage count: setup, division steps, phase, CORDIC steps, finish.
   localparam int NDiv = csdm_pkg::DivSteps;
   localparam int NCor = csdm_pkg::CordicSteps;
   localparam int NStg = 1 + NDiv + 1 + NCor + 1;

   // Pipeline advances as a whole when the final stage is free or drained.
   logic advance;
   logic [NStg-1:0] vld_ff;
   assign advance = !vld_ff[NStg-1] || out_ready;
   assign in_ready = advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (advance) begin
         vld_ff <= {vld_ff[NStg-2:0], in_valid};
      end
   end

   // Stage 0: map to Q1.15 and pick the sector.
   logic signed [16:0] a_in, b_in;
   logic [15:0] r0_in, num0_in, den0_in, off0_in;
   logic sub0_in, zero0_in, neg0_in;
   assign a_in = $signed({1'b0, in_a}) - 17'sd32768;
   assign b_in = $signed({1'b0, in_b}) - 17'sd32768;

   always_comb begin
      logic signed [16:0] n, d;
      n = '0;
      d = '0;
      sub0_in = 1'b0;
      zero0_in = 1'b0;
      off0_in = '0;
      if (a_in > -b_in) begin
         if (a_in > b_in) begin
            n = b_in; d = a_in;
         end else begin
            n = a_in; d = b_in; sub0_in = 1'b1;
            off0_in = 16'(2 * csdm_pkg::PhEighth);
         end
         r0_in = 16'(d);
      end else begin
         if (a_in < b_in) begin
            n = b_in; d = a_in;
            off0_in = 16'(4 * csdm_pkg::PhEighth);
         end else begin
            n = a_in; d = b_in; sub0_in = 1'b1;
            off0_in = 16'(6 * csdm_pkg::PhEighth);
            zero0_in = (b_in == 17'sd0);
         end
         r0_in = 16'(-d);
      end
      neg0_in = n[16] ^ d[16];
      num0_in = n[16] ? 16'(-n) : 16'(n);
      den0_in = d[16] ? 16'(-d) : 16'(d);
      if (zero0_in) begin
         den0_in = 16'd1;
      end
   end

   // Division state: numerator*8192 + den/2 divided by den, restoring.
   // The quotient fits in 14 bits since num <= den, so the top 16 dividend
   // bits start as the remainder and the low 14 bits are shifted in.
   typedef struct packed {
      logic [16:0] r;
      logic [15:0] off;
      logic sub;
      logic zero;
      logic neg;
      logic [15:0] den;
      logic [16:0] rem;
      logic [13:0] quo;
      logic [29:0] dvd;
   } dstage_type;

   dstage_type ds_ff [NDiv+1];
   dstage_type ds_in [NDiv+1];

   logic [29:0] dvd0;
   assign dvd0 = 30'({num0_in, 13'd0}) + 30'(den0_in >> 1);

   always_comb begin
      // Radius reaches 32768 at a coordinate of -1; the unsigned field holds it.
      ds_in[0].r = {1'b0, r0_in};
      ds_in[0].off = off0_in;
      ds_in[0].sub = sub0_in;
      ds_in[0].zero = zero0_in;
      ds_in[0].neg = neg0_in;
      ds_in[0].den = den0_in;
      ds_in[0].rem = {1'b0, dvd0[29:14]};
      ds_in[0].quo = '0;
      ds_in[0].dvd = {dvd0[13:0], 16'd0};
   end

   // Each division stage brings in one dividend bit and makes one quotient bit.
   for (genvar i = 0; i < NDiv; i++) begin : g_div
      always_comb begin
         logic [17:0] t;
         ds_in[i+1] = ds_ff[i];
         t = {ds_ff[i].rem, ds_ff[i].dvd[29]};
         ds_in[i+1].dvd = {ds_ff[i].dvd[28:0], 1'b0};
         if (t >= {2'b0, ds_ff[i].den}) begin
            t = t - {2'b0, ds_ff[i].den};
            ds_in[i+1].quo = {ds_ff[i].quo[12:0], 1'b1};
         end else begin
            ds_in[i+1].quo = {ds_ff[i].quo[12:0], 1'b0};
         end
         ds_in[i+1].rem = t[16:0];
      end
   end

   for (genvar i = 0; i <= NDiv; i++) begin : g_dff
      always_ff @(posedge clock) begin
         if (advance) begin
            ds_ff[i] <= ds_in[i];
         end
      end
   end

   // Phase and quadrant.
   logic [15:0] q_val, phase;
   logic [1:0] k_in;
   logic signed [15:0] z_in;
   assign q_val = ds_ff[NDiv].neg ? 16'(-{2'b0, ds_ff[NDiv].quo})
                                   : {2'b0, ds_ff[NDiv].quo};
   assign phase = ds_ff[NDiv].zero ? 16'd0
                : (ds_ff[NDiv].sub ? ds_ff[NDiv].off - q_val : ds_ff[NDiv].off + q_val);
   assign k_in = 2'((phase + 16'd8192) >> 14);
   assign z_in = $signed(phase - {k_in, 14'd0});

   // CORDIC stages.
   typedef struct packed {
      logic [1:0] k;
      logic signed [15:0] z;
      csdm_pkg::acc_type x;
      csdm_pkg::acc_type y;
   } cstage_type;

   cstage_type cs_ff [NCor+1];
   cstage_type cs_in [NCor+1];

   always_comb begin
      cs_in[0].k = k_in;
      cs_in[0].z = z_in;
      cs_in[0].x = csdm_pkg::acc_type'({19'd0, ds_ff[NDiv].r})
                 * csdm_pkg::acc_type'(csdm_pkg::CordicGain);
      cs_in[0].y = '0;
   end

   for (genvar i = 0; i < NCor; i++) begin : g_cor
      always_comb begin
         csdm_pkg::acc_type dx, dy;
         logic signed [15:0] at;
         dx = cs_ff[i].y >>> i;
         dy = cs_ff[i].x >>> i;
         at = $signed({2'b0, csdm_pkg::atan_entry(4'(i))});
         cs_in[i+1].k = cs_ff[i].k;
         if (!cs_ff[i].z[15]) begin
            cs_in[i+1].x = cs_ff[i].x - dx;
            cs_in[i+1].y = cs_ff[i].y + dy;
            cs_in[i+1].z = cs_ff[i].z - at;
         end else begin
            cs_in[i+1].x = cs_ff[i].x + dx;
            cs_in[i+1].y = cs_ff[i].y - dy;
            cs_in[i+1].z = cs_ff[i].z + at;
         end
      end
   end

   for (genvar i = 0; i <= NCor; i++) begin : g_cff
      always_ff @(posedge clock) begin
         if (advance) begin
            cs_ff[i] <= cs_in[i];
         end
      end
   end

   // Final stage: round, swap by quadrant, saturate.
   function automatic logic [15:0] sat16(input logic signed [20:0] v);
      if (v > 21'sd32767) return 16'h7FFF;
      if (v < -21'sd32768) return 16'h8000;
      return 16'(v);
   endfunction

   logic signed [20:0] xr, yr;
   logic [15:0] ox_in, oy_in, ox_ff, oy_ff;
   assign xr = 21'((cs_ff[NCor].x + 36'sd32768) >>> 16);
   assign yr = 21'((cs_ff[NCor].y + 36'sd32768) >>> 16);

   always_comb begin
      case (cs_ff[NCor].k)
         2'd0: begin ox_in = sat16(xr); oy_in = sat16(yr); end
         2'd1: begin ox_in = sat16(-yr); oy_in = sat16(xr); end
         2'd2: begin ox_in = sat16(-xr); oy_in = sat16(-yr); end
         default: begin ox_in = sat16(yr); oy_in = sat16(-xr); end
      endcase
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         ox_ff <= ox_in;
         oy_ff <= oy_in;
      end
   end

   assign out_valid = vld_ff[NStg-1];
   assign out_x = ox_ff;
   assign out_y = oy_ff;

   // A stalled result must hold until taken.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      out_valid && !out_ready |=> out_valid && $stable(out_x) && $stable(out_y))
      else $error("result changed while stalled");
   // The division remainder always stays below the divisor.
   a_rem: assert property (@(posedge clock) disable iff (reset)
      vld_ff[NDiv] |-> ds_ff[NDiv].rem < {1'b0, ds_ff[NDiv].den})
      else $error("division remainder out of range");
   // The rounded quotient never exceeds one eighth of a turn.
   a_quo: assert property (@(posedge clock) disable iff (reset)
      vld_ff[NDiv] |-> ds_ff[NDiv].quo <= 14'(csdm_pkg::PhEighth))
      else $error("ratio beyond one eighth turn");
endmodule

// ===== sim/concentric_square_to_disk_map_unit_tb.sv =====
// Self-checking testbench for the concentric square-to-disk map unit.
`timescale 1ns / 100ps

module concentric_square_to_disk_map_unit_tb;
   localparam int PipeDepth = 33;
   localparam int CycleLimit = 400000;
   localparam int PhStep = 8192;
   localparam int GainQ16 = 39797;

   typedef struct packed {
      logic signed [15:0] disk_y;
      logic signed [15:0] disk_x;
   } disk_point_type;

   logic clock;
   logic reset;
   logic req_tvalid;
   logic req_tready;
   logic [31:0] req_tdata;   // sample_x [15:0], sample_y [31:16]
   logic rsp_tvalid;
   logic rsp_tready;
   logic [31:0] rsp_tdata;   // disk_x [15:0], disk_y [31:16]

   disk_point_type pending_points[$];
   int mismatch_count = 0;
   int cycle_count = 0;
   bit stall_enable = 1'b1;

   concentric_square_to_disk_map_unit dut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata)
   );

   // Free-running clock.
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Arctangent of 2^-i in phase units.
   function automatic longint rotation_angle(input int idx);
      int angles[16] = '{8192, 4836, 2555, 1297, 651, 326, 163, 81,
                         41, 20, 10, 5, 3, 1, 1, 0};
      return angles[idx];
   endfunction

   function automatic longint floor_shift(input longint v, input int s);
      return v >>> s;
   endfunction

   function automatic logic signed [15:0] clamp16(input longint v);
      if (v > 32767) return 16'sd32767;
      if (v < -32768) return -16'sd32768;
      return v[15:0];
   endfunction

   // Rounded minor/major ratio in eighths of a turn, ties away from zero.
   function automatic int eighth_ratio(input int num, input int den);
      longint an;
      longint ad;
      longint m;
      an = num < 0 ? -num : num;
      ad = den < 0 ? -den : den;
      m = (an * PhStep + ad / 2) / ad;
      return ((num < 0) != (den < 0)) ? -int'(m) : int'(m);
   endfunction

   // Expected disk point for one sample point.
   function automatic disk_point_type map_to_disk(input logic [15:0] sx, input logic [15:0] sy);
      int a;
      int b;
      int radius;
      int ph;
      logic [15:0] phase;
      int quad;
      int z;
      longint cx;
      longint cy;
      longint dx;
      longint dy;
      disk_point_type pt;
      a = int'(sx) - 32768;
      b = int'(sy) - 32768;
      if (a > -b) begin
         if (a > b) begin
            radius = a;
            ph = eighth_ratio(b, a);
         end else begin
            radius = b;
            ph = 2 * PhStep - eighth_ratio(a, b);
         end
      end else begin
         if (a < b) begin
            radius = -a;
            ph = 4 * PhStep + eighth_ratio(b, a);
         end else begin
            radius = -b;
            ph = (b != 0) ? 6 * PhStep - eighth_ratio(a, b) : 0;
         end
      end
      phase = ph[15:0];
      quad = ((int'(phase) + 8192) >> 14) & 3;
      z = int'(16'(phase - 16'(quad * 16384) + 16'd32768)) - 32768;
      cx = longint'(radius) * GainQ16;
      cy = 0;
      for (int i = 0; i < 16; i++) begin
         dx = floor_shift(cy, i);
         dy = floor_shift(cx, i);
         if (z >= 0) begin
            cx -= dx;
            cy += dy;
            z -= int'(rotation_angle(i));
         end else begin
            cx += dx;
            cy -= dy;
            z += int'(rotation_angle(i));
         end
      end
      cx = floor_shift(cx + 32768, 16);
      cy = floor_shift(cy + 32768, 16);
      case (quad)
         0: begin pt.disk_x = clamp16(cx); pt.disk_y = clamp16(cy); end
         1: begin pt.disk_x = clamp16(-cy); pt.disk_y = clamp16(cx); end
         2: begin pt.disk_x = clamp16(-cx); pt.disk_y = clamp16(-cy); end
         default: begin pt.disk_x = clamp16(cy); pt.disk_y = clamp16(-cx); end
      endcase
      return pt;
   endfunction

   // Send one sample point, with a random gap at the end of a burst.
   int burst_left = 0;
   task automatic send_sample(input logic [15:0] sx, input logic [15:0] sy);
      req_tvalid <= 1'b1;
      req_tdata <= {sy, sx};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      pending_points = {pending_points, map_to_disk(sx, sy)};
      @(negedge clock);
      if (burst_left == 0) begin
         burst_left = $urandom_range(0, 3) == 0 ? 40 : $urandom_range(1, 12);
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(negedge clock);
      end else begin
         burst_left--;
      end
   endtask

   // Receiver stall pattern: busy and quiet stretches alternate.
   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (!stall_enable) rsp_tready <= 1'b1;
         else if ((cycle_count / 300) % 3 == 0) rsp_tready <= 1'b1;
         else rsp_tready <= ($urandom_range(0, 3) != 0);
      end
   end

   // Compare each taken result with the oldest expected point.
   always @(posedge clock) begin
      disk_point_type want;
      disk_point_type got;
      cycle_count <= cycle_count + 1;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata;
         if (pending_points.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10) $display("Unexpected result %h", rsp_tdata);
         end else begin
            want = pending_points.pop_front();
            if (got.disk_x !== want.disk_x || got.disk_y !== want.disk_y) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("Mismatch: expected x=%0d y=%0d, got x=%0d y=%0d",
                     want.disk_x, want.disk_y, got.disk_x, got.disk_y);
            end
         end
      end
   end

   // Stop a hung run.
   always @(posedge clock) begin
      if (cycle_count > CycleLimit) begin
         $display("FAIL concentric_square_to_disk_map_unit");
         $finish;
      end
   end

   // Corners, axes, origin, diagonals and sector borders.
   task automatic test_directed_points();
      logic [15:0] edges[6] = '{16'h0000, 16'h0001, 16'h7FFF, 16'h8000, 16'h8001, 16'hFFFF};
      for (int i = 0; i < 6; i++)
         for (int j = 0; j < 4; j++)
            send_sample(edges[i], edges[(j * 2 + i) % 6]);
      send_sample(16'h8000, 16'h8000);
   endtask

   // Uniform random sample points across the square.
   task automatic test_random_points();
      for (int i = 0; i < 1700; i++)
         send_sample(16'($urandom), 16'($urandom));
   endtask

   // Points on the diagonals and near the axes, where sectors meet.
   task automatic test_sector_borders();
      logic [15:0] s;
      logic [15:0] d;
      for (int i = 0; i < 300; i++) begin
         s = 16'($urandom);
         d = 16'($urandom_range(0, 2));
         case ($urandom_range(0, 3))
            0: send_sample(s, s + d);
            1: send_sample(s, 16'd0 - s + d);
            2: send_sample(s, 16'h8000 + d);
            default: send_sample(16'h8000 - d, s);
         endcase
      end
   endtask

   initial begin
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_directed_points();
      test_random_points();
      test_sector_borders();
      req_tvalid <= 1'b0;
      stall_enable = 1'b0;
      while (pending_points.size() != 0) @(posedge clock);
      repeat (PipeDepth + 10) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("PASS concentric_square_to_disk_map_unit");
      end else begin
         $display("FAIL concentric_square_to_disk_map_unit");
      end
      $finish;
   end
endmodule
